// ===== rtl/sfsu_pkg.sv =====
// Shared types, constants and helpers for the star field update block.
// Used by every module under rtl/; depends on nothing.
`default_nettype none
package sfsu_pkg;

  localparam int DEFAULT_STARS = 256;

  localparam int POS_W   = 20;  // star position, signed, 1/16 units
  localparam int DEPTH_W = 10;  // star depth
  localparam int SPEED_W = 2;   // star speed
  localparam int IDX_W   = 8;   // star index field
  localparam int RAND_W  = 16;  // random word
  localparam int CEN_W   = 11;  // centre registers
  localparam int SCR_W   = 12;  // screen size registers
  localparam int PIX_W   = 12;  // pixel coordinate
  localparam int GREY_W  = 8;
  localparam int DEN_W   = DEPTH_W + 4;  // 16 * depth
  localparam int REM_W   = 26;           // nonnegative numerator of a visible point
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  // Divider retires this many quotient bits per stage
  localparam int DIV_STEP = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

  localparam logic [CEN_W-1:0] RST_CENTER_X      = 11'd160;
  localparam logic [CEN_W-1:0] RST_CENTER_Y      = 11'd120;
  localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
  localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 12'd240;

  localparam logic OP_SPAWN   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [DEPTH_W-1:0] depth;
    logic [SPEED_W-1:0] speed;
  } star_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem_x;
    logic [REM_W-1:0]  rem_y;
    logic [DEN_W-1:0]  den;
    logic [PIX_W-1:0]  qx;
    logic [PIX_W-1:0]  qy;
    logic [GREY_W-1:0] grey;
    logic              vis;
  } div_item_t;

  // 15*r - 491520, always inside the signed 20-bit range
  function automatic logic [POS_W-1:0] spawn_pos(input logic [RAND_W-1:0] r);
    logic [POS_W:0] t;
    t = {1'b0, r, 4'b0} - {5'b0, r};
    t = t - 21'd491520;
    return t[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/starfield_star_update.sv =====
// Star field update: star table, depth step, projection and pixel output.
// Depends on sfsu_pkg, sfsu_star_mem and sfsu_div_stage.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser, one star
//   operation each (s_tuser: spawn or advance). Every beat gives exactly one
//   output beat on m_tvalid/m_tready/m_tdata/m_tuser; m_tuser marks a pixel
//   to plot, otherwise the output fields are zero.
//   From accept to the result on m_tdata a beat passes table read, depth
//   update, multiply, add/compare with table write-back folded into
//   the first of three divider stages of four quotient bits each, and the
//   output register.
//   Throughput is one beat per cycle while m_tready does not stall and no
//   advance is held: an advance beat for a star that is still in the first
//   three stages waits until that star's write-back is done.
//   A stall on m_tready backs up through the valid-tagged stages; bubbles
//   collapse, nothing is lost or repeated.
//   Reset clears all stage valids and loads the default screen set-up.
//   The table has no reset: spawn a star before it is advanced.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) are taken at once
//   and must be made only while no beat is in flight.
`default_nettype none
module starfield_star_update #(
  parameter int STARS = sfsu_pkg::DEFAULT_STARS
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // star_index, rand_x_first, rand_y_first, rand_speed_first,
  // rand_x_second, rand_y_second, rand_speed_second, zero pad
  input  wire [sfsu_pkg::IN_DATA_W-1:0]       s_tdata,
  // operation
  input  wire [0:0]                           s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // pixel_x, pixel_y, grey_level
  output logic [sfsu_pkg::OUT_DATA_W-1:0]     m_tdata,
  // visible
  output logic [0:0]                          m_tuser,
  input  wire                                 cfg_wr_en,
  input  wire [sfsu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [sfsu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = (STARS > 1) ? $clog2(STARS) : 1;

  typedef struct packed {
    logic                            op;
    logic [sfsu_pkg::IDX_W-1:0]      idx;
    logic                            in_range;
    logic [sfsu_pkg::RAND_W-1:0]     rxf;
    logic [sfsu_pkg::RAND_W-1:0]     ryf;
    logic                            rsf;
    logic [sfsu_pkg::RAND_W-1:0]     rxs;
    logic [sfsu_pkg::RAND_W-1:0]     rys;
    logic                            rss;
  } s1_t;

  typedef struct packed {
    logic                            op;
    logic [sfsu_pkg::IDX_W-1:0]      idx;
    logic                            in_range;
    sfsu_pkg::star_t                 sa;
    sfsu_pkg::star_t                 sb;
    logic [sfsu_pkg::GREY_W-1:0]     grey;
  } s2_t;

  typedef struct packed {
    logic                            op;
    logic [sfsu_pkg::IDX_W-1:0]      idx;
    logic                            in_range;
    sfsu_pkg::star_t                 sa;
    sfsu_pkg::star_t                 sb;
    logic [sfsu_pkg::GREY_W-1:0]     grey;
    logic [20:0]                     pcx;
    logic [20:0]                     pcy;
    logic [21:0]                     pw;
    logic [21:0]                     ph;
  } s3_t;

  // configuration
  logic [sfsu_pkg::CEN_W-1:0] center_x;
  logic [sfsu_pkg::CEN_W-1:0] center_y;
  logic [sfsu_pkg::SCR_W-1:0] screen_width;
  logic [sfsu_pkg::SCR_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= sfsu_pkg::RST_CENTER_X;
      center_y      <= sfsu_pkg::RST_CENTER_Y;
      screen_width  <= sfsu_pkg::RST_SCREEN_WIDTH;
      screen_height <= sfsu_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sfsu_pkg::CFG_CENTER_X:      center_x      <= cfg_data[sfsu_pkg::CEN_W-1:0];
        sfsu_pkg::CFG_CENTER_Y:      center_y      <= cfg_data[sfsu_pkg::CEN_W-1:0];
        sfsu_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        sfsu_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic v1, v2, v3;
  s1_t  p1;
  s2_t  p2;
  s3_t  p3;
  logic rdy1, rdy2, rdy3;
  logic d1_ready, d2_ready, d3_ready;
  logic d1_valid, d2_valid, d3_valid;
  sfsu_pkg::div_item_t d1_item, d2_item, d3_item, d0_item;

  sfsu_pkg::star_t rd_data;
  sfsu_pkg::star_t wr_data;
  logic            wr_en;

  // input unpack
  logic                        in_op;
  logic [sfsu_pkg::IDX_W-1:0]  in_idx;
  logic                        hazard;
  logic                        accept;

  assign in_op  = s_tuser[0];
  assign in_idx = s_tdata[7:0];

  // hold an advance while its star is still before write-back
  assign hazard = (in_op == sfsu_pkg::OP_ADVANCE) &&
                  ((v1 && p1.idx == in_idx) || (v2 && p2.idx == in_idx) ||
                   (v3 && p3.idx == in_idx));

  assign rdy3     = !v3 || d1_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1 && !hazard;
  assign accept   = s_tvalid && s_tready;

  sfsu_star_mem #(
    .DEPTH(STARS),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(p3.idx)),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(AW'(in_idx)),
    .rd_data(rd_data)
  );

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1.op       <= in_op;
      p1.idx      <= in_idx;
      p1.in_range <= ({2'b0, in_idx} < 10'(STARS));
      p1.rxf      <= s_tdata[23:8];
      p1.ryf      <= s_tdata[39:24];
      p1.rsf      <= s_tdata[40];
      p1.rxs      <= s_tdata[56:41];
      p1.rys      <= s_tdata[72:57];
      p1.rss      <= s_tdata[73];
    end
  end

  // stage 1: depth step and first respawn
  s2_t  s2_next;
  logic [sfsu_pkg::DEPTH_W:0]   dsub;
  logic [sfsu_pkg::DEPTH_W-1:0] spawn_depth;
  logic [6:0]                   gc;
  logic                         respawn;

  always_comb begin
    dsub        = {1'b0, rd_data.depth} - {9'b0, rd_data.speed};
    respawn     = (p1.op == sfsu_pkg::OP_SPAWN) || dsub[sfsu_pkg::DEPTH_W] ||
                  (dsub == '0);
    spawn_depth = {2'b0, p1.idx} + 10'd1;
    gc          = spawn_depth[8:2];

    s2_next.op       = p1.op;
    s2_next.idx      = p1.idx;
    s2_next.in_range = p1.in_range;
    if (respawn) begin
      s2_next.sa.x     = sfsu_pkg::spawn_pos(p1.rxf);
      s2_next.sa.y     = sfsu_pkg::spawn_pos(p1.ryf);
      s2_next.sa.depth = spawn_depth;
      s2_next.sa.speed = {1'b1, p1.rsf};
    end else begin
      s2_next.sa.x     = rd_data.x;
      s2_next.sa.y     = rd_data.y;
      s2_next.sa.depth = dsub[sfsu_pkg::DEPTH_W-1:0];
      s2_next.sa.speed = rd_data.speed;
    end
    s2_next.sb.x     = sfsu_pkg::spawn_pos(p1.rxs);
    s2_next.sb.y     = sfsu_pkg::spawn_pos(p1.rys);
    s2_next.sb.depth = spawn_depth;
    s2_next.sb.speed = {1'b1, p1.rss};
    s2_next.grey     = (gc == '0) ? 8'd0 : (8'd255 - {1'b0, gc});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p2 <= s2_next;
    end
  end

  // stage 2: scale depth by centre and screen size
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      p3.op       <= p2.op;
      p3.idx      <= p2.idx;
      p3.in_range <= p2.in_range;
      p3.sa       <= p2.sa;
      p3.sb       <= p2.sb;
      p3.grey     <= p2.grey;
      p3.pcx      <= p2.sa.depth * center_x;
      p3.pcy      <= p2.sa.depth * center_y;
      p3.pw       <= p2.sa.depth * screen_width;
      p3.ph       <= p2.sa.depth * screen_height;
    end
  end

  // stage 3: numerators, visibility window, table write-back
  logic [26:0]                num_x, num_y;
  logic [27:0]                sum_x, sum_y;
  logic [27:0]                lim_x, lim_y;
  logic [sfsu_pkg::DEN_W-1:0] den;
  logic                       adv, vis;

  always_comb begin
    den   = {p3.sa.depth, 4'b0};
    num_x = {{7{p3.sa.x[19]}}, p3.sa.x} + {2'b0, p3.pcx, 4'b0};
    num_y = {{7{p3.sa.y[19]}}, p3.sa.y} + {2'b0, p3.pcy, 4'b0};
    sum_x = {num_x[26], num_x} + 28'(den);
    sum_y = {num_y[26], num_y} + 28'(den);
    lim_x = {2'b0, p3.pw, 4'b0};
    lim_y = {2'b0, p3.ph, 4'b0};
    adv   = (p3.op == sfsu_pkg::OP_ADVANCE) && p3.in_range;
    // on screen: -den < num < 16*depth*size, and a nonzero screen
    vis   = adv && (screen_width != '0) && (screen_height != '0) &&
            !sum_x[27] && (sum_x != '0) && !sum_y[27] && (sum_y != '0) &&
            ($signed({num_x[26], num_x}) < $signed(lim_x)) &&
            ($signed({num_y[26], num_y}) < $signed(lim_y));

    wr_data = (adv && !vis) ? p3.sb : p3.sa;

    d0_item.den   = den;
    d0_item.rem_x = (vis && !num_x[26]) ? num_x[sfsu_pkg::REM_W-1:0] : '0;
    d0_item.rem_y = (vis && !num_y[26]) ? num_y[sfsu_pkg::REM_W-1:0] : '0;
    d0_item.qx    = '0;
    d0_item.qy    = '0;
    d0_item.grey  = vis ? p3.grey : '0;
    d0_item.vis   = vis;
  end

  assign wr_en = v3 && d1_ready && p3.in_range;

  sfsu_div_stage #(.LOW_BIT(8)) u_div_hi (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_ready (d1_ready),
    .in_item  (d0_item),
    .out_valid(d1_valid),
    .out_ready(d2_ready),
    .out_item (d1_item)
  );

  sfsu_div_stage #(.LOW_BIT(4)) u_div_mid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d1_valid),
    .in_ready (d2_ready),
    .in_item  (d1_item),
    .out_valid(d2_valid),
    .out_ready(d3_ready),
    .out_item (d2_item)
  );

  logic out_rdy;
  assign out_rdy = !m_tvalid || m_tready;

  sfsu_div_stage #(.LOW_BIT(0)) u_div_lo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d2_valid),
    .in_ready (d3_ready),
    .in_item  (d2_item),
    .out_valid(d3_valid),
    .out_ready(out_rdy),
    .out_item (d3_item)
  );

  // output register; zero the fields of a beat with no pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_rdy) begin
      m_tvalid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && d3_valid) begin
      m_tdata <= d3_item.vis ? {d3_item.grey, d3_item.qy, d3_item.qx} : '0;
      m_tuser <= d3_item.vis;
    end
  end

`ifndef SYNTHESIS
  a_no_raw_overlap: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && p1.op == sfsu_pkg::OP_ADVANCE) |-> (p1.idx != p2.idx))
    else $error("advance overlaps a pending write of the same star");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("result without pixel carries nonzero fields");

  a_pixel_on_screen: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[11:0] < screen_width) && (m_tdata[23:12] < screen_height))
    else $error("plotted pixel outside the screen");

  a_write_on_advance: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (v3 && d1_ready))
    else $error("table written without a stage 3 beat moving on");
`endif

endmodule
`default_nettype wire

// ===== rtl/sfsu_star_mem.sv =====
// Star table: one write port, one read port with registered read data.
// Depends on sfsu_pkg for the star entry type.
`default_nettype none
module sfsu_star_mem #(
  parameter int DEPTH = sfsu_pkg::DEFAULT_STARS,
  parameter int AW    = 8
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [AW-1:0]         wr_addr,
  input  sfsu_pkg::star_t      wr_data,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output sfsu_pkg::star_t      rd_data
);

  sfsu_pkg::star_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfsu_div_stage.sv =====
// One pipeline stage of the restoring divider: retires DIV_STEP quotient bits
// for both axes. Depends on sfsu_pkg for the stage payload type.
`default_nettype none
module sfsu_div_stage #(
  parameter int LOW_BIT = 0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sfsu_pkg::div_item_t   in_item,
  output logic                  out_valid,
  input  wire                   out_ready,
  output sfsu_pkg::div_item_t   out_item
);

  localparam int TW = sfsu_pkg::REM_W + 1;

  sfsu_pkg::div_item_t item_next;

  always_comb begin
    logic [TW-1:0] rx;
    logic [TW-1:0] ry;
    logic [TW-1:0] sh;
    item_next = in_item;
    rx = {1'b0, in_item.rem_x};
    ry = {1'b0, in_item.rem_y};
    for (int k = LOW_BIT + sfsu_pkg::DIV_STEP - 1; k >= LOW_BIT; k--) begin
      sh = TW'(in_item.den) << k;
      if (rx >= sh) begin
        rx = rx - sh;
        item_next.qx[k] = 1'b1;
      end
      if (ry >= sh) begin
        ry = ry - sh;
        item_next.qy[k] = 1'b1;
      end
    end
    item_next.rem_x = rx[sfsu_pkg::REM_W-1:0];
    item_next.rem_y = ry[sfsu_pkg::REM_W-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire
